@@ rtl/ieia_pkg.sv @@
// Package for the indexed insert/erase array: operation codes, status codes
// and the result record passed from the sequencer to the top level.
// No dependencies.
`default_nettype none
package ieia_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_TAKE,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] data;
    status_t           status;
  } seq_res_t;

endpackage
`default_nettype wire

@@ rtl/ieia_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ieia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/ieia_seq.sv @@
// Sequencer for the indexed insert/erase array: checks each request, then
// moves entries one at a time through the shared RAM port. Uses ieia_pkg.
`default_nettype none
module ieia_seq #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [ieia_pkg::OP_W-1:0]         operation,
  input  wire logic [ieia_pkg::POS_W-1:0]        position,
  input  wire logic [ieia_pkg::WORD_W-1:0]       value,
  input  wire logic                              out_free,
  output      ieia_pkg::seq_res_t                res,
  output      logic [$clog2(CAPACITY+1)-1:0]     count,
  output      logic                              ram_we,
  output      logic [$clog2(CAPACITY)-1:0]       ram_waddr,
  output      logic [ieia_pkg::WORD_W-1:0]       ram_wdata,
  output      logic [$clog2(CAPACITY)-1:0]       ram_raddr,
  input  wire logic [ieia_pkg::WORD_W-1:0]       ram_rdata
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > ieia_pkg::POS_W) ? CW : ieia_pkg::POS_W;
  localparam int unsigned EW   = CMPW + 1;

  ieia_pkg::seq_state_t state, state_next;

  logic [ieia_pkg::OP_W-1:0]   op_q;
  logic [ieia_pkg::POS_W-1:0]  pos_q;
  logic [ieia_pkg::WORD_W-1:0] val_q;
  logic [AW-1:0]               idx, idx_next;
  logic [CW-1:0]               count_next;
  logic [ieia_pkg::WORD_W-1:0] data_q, data_next;
  ieia_pkg::status_t           status_q, status_next;

  logic              accept;
  ieia_pkg::status_t acc_status;
  logic [EW-1:0]     pos_in_e, pos_q_e, count_e, idx_e;
  logic              is_full;

  assign accept   = in_valid && (state == ieia_pkg::S_IDLE);
  assign pos_in_e = EW'(position);
  assign pos_q_e  = EW'(pos_q);
  assign count_e  = EW'(count);
  assign idx_e    = EW'(idx);
  assign is_full  = (count == CW'(CAPACITY));

  // Admission check on the incoming request.
  always_comb begin
    case (operation)
      ieia_pkg::OP_INSERT: begin
        if (is_full) begin
          acc_status = ieia_pkg::ST_FULL;
        end else if (pos_in_e > count_e) begin
          acc_status = ieia_pkg::ST_RANGE;
        end else begin
          acc_status = ieia_pkg::ST_OK;
        end
      end
      ieia_pkg::OP_ERASE, ieia_pkg::OP_READ: begin
        acc_status = (pos_in_e >= count_e) ? ieia_pkg::ST_RANGE : ieia_pkg::ST_OK;
      end
      default: acc_status = ieia_pkg::ST_RANGE;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ieia_pkg::S_IDLE: begin
        if (accept) begin
          if (acc_status != ieia_pkg::ST_OK) begin
            state_next = ieia_pkg::S_DONE;
          end else if (operation == ieia_pkg::OP_INSERT) begin
            state_next = (pos_in_e == count_e) ? ieia_pkg::S_PUT : ieia_pkg::S_MV_RD;
          end else begin
            state_next = ieia_pkg::S_FETCH;
          end
        end
      end
      ieia_pkg::S_FETCH: state_next = ieia_pkg::S_TAKE;
      ieia_pkg::S_TAKE: begin
        if (op_q == ieia_pkg::OP_ERASE && pos_q_e + EW'(1) != count_e) begin
          state_next = ieia_pkg::S_MV_RD;
        end else begin
          state_next = ieia_pkg::S_DONE;
        end
      end
      ieia_pkg::S_MV_RD: state_next = ieia_pkg::S_MV_WR;
      ieia_pkg::S_MV_WR: begin
        if (op_q == ieia_pkg::OP_INSERT) begin
          state_next = (idx_e == pos_q_e + EW'(1)) ? ieia_pkg::S_PUT : ieia_pkg::S_MV_RD;
        end else begin
          state_next = (idx_e + EW'(2) == count_e) ? ieia_pkg::S_DONE : ieia_pkg::S_MV_RD;
        end
      end
      ieia_pkg::S_PUT: state_next = ieia_pkg::S_DONE;
      ieia_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ieia_pkg::S_IDLE;
        end
      end
      default: state_next = ieia_pkg::S_IDLE;
    endcase
  end

  // Outputs: RAM port control, handshake and result.
  always_comb begin
    in_stall   = (state != ieia_pkg::S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ram_rdata;
    ram_raddr  = AW'(pos_q_e);
    res.done   = 1'b0;
    res.data   = data_q;
    res.status = status_q;
    case (state)
      ieia_pkg::S_MV_RD: begin
        ram_raddr = (op_q == ieia_pkg::OP_INSERT) ? idx - AW'(1) : idx + AW'(1);
      end
      ieia_pkg::S_MV_WR: ram_we = 1'b1;
      ieia_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q_e);
        ram_wdata = val_q;
      end
      ieia_pkg::S_DONE: res.done = out_free;
      default: ;
    endcase
  end

  // Working registers: index, count and the result being built.
  always_comb begin
    idx_next    = idx;
    count_next  = count;
    data_next   = data_q;
    status_next = status_q;
    case (state)
      ieia_pkg::S_IDLE: begin
        if (accept) begin
          idx_next    = AW'(count_e);
          data_next   = '0;
          status_next = acc_status;
        end
      end
      ieia_pkg::S_TAKE: begin
        if (op_q == ieia_pkg::OP_ERASE) begin
          data_next = ram_rdata;
          idx_next  = AW'(pos_q_e);
          if (pos_q_e + EW'(1) == count_e) begin
            count_next = count - CW'(1);
          end
        end else begin
          data_next = ram_rdata;
        end
      end
      ieia_pkg::S_MV_WR: begin
        if (op_q == ieia_pkg::OP_INSERT) begin
          idx_next = idx - AW'(1);
        end else begin
          idx_next = idx + AW'(1);
          if (idx_e + EW'(2) == count_e) begin
            count_next = count - CW'(1);
          end
        end
      end
      ieia_pkg::S_PUT: count_next = count + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ieia_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      pos_q <= position;
      val_q <= value;
    end
    idx      <= idx_next;
    data_q   <= data_next;
    status_q <= status_next;
  end

endmodule
`default_nettype wire

@@ rtl/indexed_insert_erase_array_top.sv @@
// Top level of the indexed insert/erase array: sequencer, entry RAM and the
// result register. Uses ieia_pkg, ieia_seq and ieia_ram.
`default_nettype none
//
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------
//  in      | in_valid, in_stall | operation, position, value
//  out     | out_valid,out_stall| read_data, entry_count, status
//
// Every request yields exactly one result; in an insert or an erase, each moved
// entry costs one read and one write on the RAM port.
// A synchronous reset empties the list; the entry storage itself is not cleared.
// A new request is taken while the previous result still waits in the output
// register; a result that cannot be delivered holds the sequencer until it can.
module indexed_insert_erase_array_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [1:0]                         operation,
  input  wire logic [3:0]                         position,
  input  wire logic signed [31:0]                 value,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic signed [31:0]                 read_data,
  output      logic [$clog2(CAPACITY+1)-1:0]      entry_count,
  output      logic [1:0]                         status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ieia_pkg::seq_res_t          res;
  logic [CW-1:0]               count;
  logic                        out_free;
  logic                        out_valid_next;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [ieia_pkg::WORD_W-1:0] ram_wdata;
  logic [ieia_pkg::WORD_W-1:0] ram_rdata;

  // The output register is free when empty or when its result leaves now.
  assign out_free = !out_valid || !out_stall;

  ieia_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .position  (position),
    .value     (value),
    .out_free  (out_free),
    .res       (res),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Entry storage; only positions below the count are ever read back.
  ieia_ram #(
    .WIDTH (ieia_pkg::WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The result register loads when the sequencer finishes a request and
  // empties when the consumer takes it without a new one arriving.
  always_comb begin
    out_valid_next = out_valid;
    if (res.done) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      read_data   <= res.data;
      entry_count <= count;
      status      <= res.status;
    end
  end

  // The count can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A full report only comes with a full list.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ieia_pkg::ST_FULL) |-> entry_count == CW'(CAPACITY))
    else $error("full status with room left");

  // A rejected request returns no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ieia_pkg::ST_OK) |-> read_data == '0)
    else $error("data returned on a rejected request");

  // A finished result is only produced when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.done |-> out_free)
    else $error("result produced while output register is held");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for indexed_insert_erase_array_top: a directed table,
// then random list traffic, each result checked against a typed result from
// its row or an internal list predictor. Depends on ieia_pkg and the top level.
`default_nettype none
module tb_top;

  // The list holds sixteen entries, so the count needs five bits.
  localparam int LIST_DEPTH = 16;
  localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
  // Operation code 3 is not defined by the block and must be rejected.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int RANDOM_REQUESTS = 1250;
  // The slowest request is an erase at the front of a full list; the tail
  // wait after the last result covers that.
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  // At most a few requests are in flight, so a small ring holds them all.
  localparam int WANT_SLOTS = 8;
  localparam int STEP_SLOTS = 32;

  typedef struct packed {
    logic signed [31:0]   data;
    logic [COUNT_W-1:0]   count;
    ieia_pkg::status_t    status;
  } list_result_t;

  // One row of the directed table. A row may be repeated, with the value
  // stepped by one on each repeat; a typed result is only given for rows
  // that run once.
  typedef struct {
    logic [1:0]         op;
    logic [3:0]         pos;
    logic signed [31:0] val;
    int                 reps;
    bit                 typed;
    list_result_t       typed_res;
  } list_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = ieia_pkg::OP_READ;
  logic [3:0] position = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] read_data;
  logic [COUNT_W-1:0] entry_count;
  logic [1:0] status;

  // Shadow copy of the list contents as the predictor sees them.
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int shadow_count = 0;

  // Expected results in request order; the write and read counters only grow.
  list_result_t want_ring [WANT_SLOTS];
  int want_wr = 0;
  int want_rd = 0;

  list_step_t step_table [STEP_SLOTS];
  int step_total = 0;
  int fault_count = 0;
  int result_index = 0;

  // Sender pacing: the requests left in the current burst.
  int burst_left = 0;

  // Receiver stall pattern: a mode held for a random span of cycles.
  int stall_mode = 0;
  int stall_span = 0;
  int cycle_count = 0;

  indexed_insert_erase_array_top #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .entry_count(entry_count),
    .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, several times the slowest legal run.
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  // Applies one request to the shadow list and returns the result the
  // block must give for it. Insert checks for a full list before it checks
  // the position; every rejected request leaves the list untouched and
  // returns zero data.
  function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                 input logic [3:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t r;
    int p;
    int i;
    p = int'(pos);
    r.data = '0;
    r.status = ieia_pkg::ST_OK;
    case (op)
      ieia_pkg::OP_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ieia_pkg::ST_FULL;
        end else if (p > shadow_count) begin
          r.status = ieia_pkg::ST_RANGE;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_count++;
        end
      end
      ieia_pkg::OP_ERASE: begin
        if (p >= shadow_count) begin
          r.status = ieia_pkg::ST_RANGE;
        end else begin
          r.data = shadow_list[p];
          for (i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      ieia_pkg::OP_READ: begin
        if (p >= shadow_count) begin
          r.status = ieia_pkg::ST_RANGE;
        end else begin
          r.data = shadow_list[p];
        end
      end
      default: begin
        r.status = ieia_pkg::ST_RANGE;
      end
    endcase
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  // Adds a row to the directed table.
  task automatic add_step(input logic [1:0] op, input logic [3:0] pos,
                          input logic signed [31:0] val, input int reps,
                          input bit typed, input logic signed [31:0] t_data,
                          input int t_count, input ieia_pkg::status_t t_status);
    list_step_t s;
    s.op = op;
    s.pos = pos;
    s.val = val;
    s.reps = reps;
    s.typed = typed;
    s.typed_res.data = t_data;
    s.typed_res.count = COUNT_W'(t_count);
    s.typed_res.status = t_status;
    step_table[step_total] = s;
    step_total++;
  endtask

  // Presents one request and holds it until the block takes it. The stall
  // is looked at on the falling edge, where both it and valid have settled,
  // so the handshake at the next rising edge is known without a race. The
  // expectation is queued once the request has gone in, and then the sender
  // may pause before its next burst.
  task automatic send_request(input logic [1:0] op, input logic [3:0] pos,
                              input logic signed [31:0] val, input bit typed,
                              input list_result_t typed_res);
    list_result_t predicted;
    bit taken;
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    position <= pos;
    value <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    predicted = apply_list_op(op, pos, val);
    want_ring[want_wr % WANT_SLOTS] = typed ? typed_res : predicted;
    want_wr++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // A new burst starts. Gaps range past the longest request so that
      // they land on every phase of a shift; some bursts follow with none.
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Builds one random request from the current list state. Most requests
  // are legal for the present count, with a bias toward the ends of the
  // list where front and back pushes and pops happen; the rest use any
  // position, and a few carry the undefined operation code.
  bit filling = 1'b1;

  task automatic random_request();
    logic [1:0] op;
    logic [3:0] pos;
    logic signed [31:0] val;
    list_result_t none;
    int pick;
    int hi;
    none = '0;
    if (shadow_count == LIST_DEPTH) filling = 1'b0;
    else if (shadow_count == 0) filling = 1'b1;
    else if ($urandom_range(0, 99) < 2) filling = !filling;

    pick = $urandom_range(0, 99);
    if (pick < 3) op = OP_UNDEFINED;
    else if (filling) op = (pick < 65) ? ieia_pkg::OP_INSERT :
                           (pick < 82) ? ieia_pkg::OP_ERASE : ieia_pkg::OP_READ;
    else op = (pick < 30) ? ieia_pkg::OP_INSERT :
              (pick < 75) ? ieia_pkg::OP_ERASE : ieia_pkg::OP_READ;

    hi = (op == ieia_pkg::OP_INSERT) ? shadow_count : shadow_count - 1;
    if (hi > LIST_DEPTH - 1) hi = LIST_DEPTH - 1;
    pick = $urandom_range(0, 99);
    if (hi < 0 || pick >= 85) pos = 4'($urandom_range(0, LIST_DEPTH - 1));
    else if (pick < 10) pos = 4'(0);
    else if (pick < 20) pos = 4'(hi);
    else pos = 4'($urandom_range(0, hi));

    pick = $urandom_range(0, 99);
    if (pick < 80) val = $urandom;
    else if (pick < 85) val = 32'sh8000_0000;
    else if (pick < 90) val = 32'sh7fff_ffff;
    else if (pick < 93) val = -32'sd1;
    else val = $urandom_range(0, 15);

    send_request(op, pos, val, 1'b0, none);
  endtask

  // Receiver side: the stall follows one of four patterns, each held for a
  // random number of cycles (never, light, heavy, periodic).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count % 3 == 0);
    endcase
  end

  // Result checker. A result goes out at the rising edge after a falling
  // edge on which valid is high and stall low, so it is compared there
  // against the oldest expectation, field by field.
  always @(negedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (want_wr == want_rd) begin
        fault_count <= fault_count + 1;
        if (fault_count < REPORT_LIMIT) begin
          $display("tb_top: result %0d arrived with none expected: data %0d count %0d status %0d",
                   result_index, read_data, entry_count, status);
        end
      end else begin
        want = want_ring[want_rd % WANT_SLOTS];
        want_rd++;
        if (read_data !== want.data || entry_count !== want.count ||
            status !== want.status) begin
          fault_count <= fault_count + 1;
          if (fault_count < REPORT_LIMIT) begin
            $display("tb_top: result %0d mismatch: data %0d/%0d count %0d/%0d status %0d/%0d",
                     result_index, want.data, read_data, want.count, entry_count,
                     want.status, status);
          end
        end
      end
      result_index <= result_index + 1;
    end
  end

  // Main sequence.
  initial begin
    list_step_t s;
    int k;
    int i;

    // Directed table. It starts on an empty list, fills it to the top,
    // probes the full list, then empties it again.
    add_step(ieia_pkg::OP_READ, 4'd0, 32'sd0, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_ERASE, 4'd15, 32'sd0, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);
    add_step(OP_UNDEFINED, 4'd0, -32'sd1, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_INSERT, 4'd1, 32'sd5, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_INSERT, 4'd0, 32'sh8000_0000, 1, 1'b1, 32'sd0, 1,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_INSERT, 4'd1, 32'sh7fff_ffff, 1, 1'b1, 32'sd0, 2,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd0, 32'sd0, 1, 1'b1, 32'sh8000_0000, 2,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd1, 32'sd0, 1, 1'b1, 32'sh7fff_ffff, 2,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_INSERT, 4'd1, -32'sd1, 1, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd2, 32'sd0, 1, 1'b1, 32'sh7fff_ffff, 3,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd3, 32'sd0, 1, 1'b1, 32'sd0, 3, ieia_pkg::ST_RANGE);
    // Thirteen pushes at the front bring the list to capacity.
    add_step(ieia_pkg::OP_INSERT, 4'd0, 32'sh5a5a_5a5a, 13, 1'b0, 32'sd0, 0,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_INSERT, 4'd0, 32'sd9, 1, 1'b1, 32'sd0, 16, ieia_pkg::ST_FULL);
    add_step(ieia_pkg::OP_INSERT, 4'd15, 32'sd1, 1, 1'b1, 32'sd0, 16, ieia_pkg::ST_FULL);
    add_step(ieia_pkg::OP_READ, 4'd15, 32'sd0, 1, 1'b1, 32'sh7fff_ffff, 16,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd0, 32'sd0, 1, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_ERASE, 4'd15, 32'sd0, 1, 1'b1, 32'sh7fff_ffff, 15,
             ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_ERASE, 4'd0, 32'sd0, 1, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd14, 32'sd0, 1, 1'b1, 32'sd0, 14, ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_INSERT, 4'd14, 32'sd0, 1, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    add_step(OP_UNDEFINED, 4'd15, 32'sh7fff_ffff, 1, 1'b1, 32'sd0, 15,
             ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_ERASE, 4'd7, 32'sd0, 1, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    // Pops from the front drain the list completely.
    add_step(ieia_pkg::OP_ERASE, 4'd0, 32'sd0, 14, 1'b0, 32'sd0, 0, ieia_pkg::ST_OK);
    add_step(ieia_pkg::OP_READ, 4'd0, 32'sd0, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);
    add_step(ieia_pkg::OP_ERASE, 4'd0, 32'sd0, 1, 1'b1, 32'sd0, 0, ieia_pkg::ST_RANGE);

    // Reset is held from the start and then released for good.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < step_total; i++) begin
      s = step_table[i];
      for (k = 0; k < s.reps; k++) begin
        send_request(s.op, s.pos, s.val + k, s.typed, s.typed_res);
      end
    end

    repeat (RANDOM_REQUESTS) random_request();
    in_valid <= 1'b0;

    // Let every expected result come back, then give the block time to
    // show any result that it should not produce.
    while (want_wr != want_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
